// ===== rtl/ifrr_pkg.sv =====
// shared types, codes and helpers for the input focus region router
`default_nettype none

package ifrr_pkg;

    localparam int MAX_REGIONS_DEF = 16;

    localparam int EDGE_W = 20;
    localparam int POS_W  = 16;
    localparam int FRAC_W = 4;

    // function codes
    localparam logic [1:0] FUNC_BEGIN    = 2'd0;
    localparam logic [1:0] FUNC_REGISTER = 2'd1;
    localparam logic [1:0] FUNC_RESOLVE  = 2'd2;

    // layer codes
    localparam logic [1:0] LAYER_SYSTEM = 2'd0;
    localparam logic [1:0] LAYER_UI     = 2'd1;
    localparam logic [1:0] LAYER_GAME   = 2'd2;

    // event kinds
    localparam logic [2:0] KIND_BUTTON   = 3'd0;
    localparam logic [2:0] KIND_MOVE     = 3'd1;
    localparam logic [2:0] KIND_WHEEL    = 3'd2;
    localparam logic [2:0] KIND_KEYBOARD = 3'd3;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_SCAN
    } state_t;

    typedef struct packed {
        logic [1:0]               func;
        logic                     disable_flag;
        logic                     text_entry_flag;
        logic signed [EDGE_W-1:0] edge_left;
        logic signed [EDGE_W-1:0] edge_top;
        logic signed [EDGE_W-1:0] edge_right;
        logic signed [EDGE_W-1:0] edge_bottom;
        logic [1:0]               layer_code;
        logic [2:0]               event_kind;
        logic                     button_down;
        logic signed [POS_W-1:0]  pointer_x;
        logic signed [POS_W-1:0]  pointer_y;
    } in_word_t;

    typedef struct packed {
        logic [1:0] routed_layer;
        logic       region_dropped;
    } out_word_t;

    // one stored rectangle
    typedef struct packed {
        logic signed [EDGE_W-1:0] left;
        logic signed [EDGE_W-1:0] top;
        logic signed [EDGE_W-1:0] right;
        logic signed [EDGE_W-1:0] bottom;
        logic [1:0]               layer;
    } region_t;

    // hit-test query moving down the cell row
    typedef struct packed {
        logic                     valid;
        logic signed [EDGE_W-1:0] x;
        logic signed [EDGE_W-1:0] y;
        logic                     hit;
        logic [1:0]               layer;
    } probe_t;

    // pixel position to edge fixed point
    function automatic logic signed [EDGE_W-1:0] pos_to_fix(
        input logic signed [POS_W-1:0] pos
    );
        return $signed({pos, {FRAC_W{1'b0}}});
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ifrr_cell.sv =====
// one region slot: holds a rectangle, shifts it on append, tests the passing probe
`default_nettype none

module ifrr_cell #(
    parameter int CNT_W = 5
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                shift_en,
    input  wire ifrr_pkg::region_t   region_in,
    output ifrr_pkg::region_t        region_out,
    input  wire ifrr_pkg::probe_t    probe_in,
    input  wire logic [CNT_W-1:0]    left_in,
    output ifrr_pkg::probe_t         probe_out,
    output logic [CNT_W-1:0]         left_out
);
    import ifrr_pkg::*;

    region_t          region_reg;
    probe_t           probe_reg;
    logic             probe_valid_reg;
    probe_t           probe_next;
    logic [CNT_W-1:0] left_reg;
    logic [CNT_W-1:0] left_next;
    logic             in_rect;

    // slot is live only while the remaining count is nonzero
    always_comb
    begin
        in_rect = (left_in != '0) &&
                  (probe_in.x >= region_reg.left) && (probe_in.x < region_reg.right) &&
                  (probe_in.y >= region_reg.top)  && (probe_in.y < region_reg.bottom);
        probe_next = probe_in;
        if (probe_in.valid && !probe_in.hit && in_rect)
        begin
            probe_next.hit   = 1'b1;
            probe_next.layer = region_reg.layer;
        end
        left_next = (left_in != '0) ? left_in - 1'b1 : '0;
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            region_reg <= region_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_valid_reg <= 1'b0;
        end
        else
        begin
            probe_valid_reg <= probe_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        probe_reg <= probe_next;
        left_reg  <= left_next;
    end

    // valid comes from the reset flop, the rest from the data flops
    always_comb
    begin
        probe_out       = probe_reg;
        probe_out.valid = probe_valid_reg;
    end

    assign region_out = region_reg;
    assign left_out   = left_reg;

endmodule

`default_nettype wire

// ===== rtl/ifrr_chain.sv =====
// row of region cells, newest rectangle in the first cell
`default_nettype none

module ifrr_chain #(
    parameter int MAX_REGIONS = ifrr_pkg::MAX_REGIONS_DEF,
    parameter int CNT_W       = $clog2(MAX_REGIONS + 1)
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               shift_en,
    input  wire ifrr_pkg::region_t  region_new,
    input  wire ifrr_pkg::probe_t   probe_in,
    input  wire logic [CNT_W-1:0]   count_in,
    output ifrr_pkg::probe_t        probe_out
);
    import ifrr_pkg::*;

    region_t          region_link [0:MAX_REGIONS];
    probe_t           probe_link  [0:MAX_REGIONS];
    logic [CNT_W-1:0] left_link   [0:MAX_REGIONS];

    assign region_link[0] = region_new;
    assign probe_link[0]  = probe_in;
    assign left_link[0]   = count_in;

    for (genvar k = 0; k < MAX_REGIONS; k++)
    begin : g_cell
        ifrr_cell #(
            .CNT_W (CNT_W)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .shift_en   (shift_en),
            .region_in  (region_link[k]),
            .region_out (region_link[k+1]),
            .probe_in   (probe_link[k]),
            .left_in    (left_link[k]),
            .probe_out  (probe_link[k+1]),
            .left_out   (left_link[k+1])
        );
    end

    assign probe_out = probe_link[MAX_REGIONS];

endmodule

`default_nettype wire

// ===== rtl/input_focus_region_router.sv =====
// top level of the input focus region router: control, focus state and result register
//
// usage: one request channel (req_valid / req_ready / req) and one response
// channel (rsp_valid / rsp_ready / rsp); every request word yields exactly one
// response word, in order
// begin frame empties the region table and latches the disabled and text-entry
// flags; register appends a rectangle at the head of the cell row (newest first)
// or flags it dropped; resolve routes an event to system, UI or gameplay
// response: begin, register and resolves that need no hit test answer in the cycle
// after acceptance; button presses, moves and wheel events send a probe down
// the row of MAX_REGIONS cells, one cell per cycle, and answer once the probe
// leaves the last cell and its result is registered
// throughput: one word per cycle for words without a hit test while each response
// is taken at once; no word is taken while probing; one word in flight at a time
// reset: table empty, no frame seen, focus on system, no response pending
// stall: a waiting response holds in its register; a new request is taken in
// the same cycle the held response leaves
`default_nettype none

module input_focus_region_router #(
    parameter int MAX_REGIONS = ifrr_pkg::MAX_REGIONS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 req_valid,
    output logic                      req_ready,
    input  wire ifrr_pkg::in_word_t   req,
    output logic                      rsp_valid,
    input  wire logic                 rsp_ready,
    output ifrr_pkg::out_word_t       rsp
);
    import ifrr_pkg::*;

    localparam int CNT_W = $clog2(MAX_REGIONS + 1);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             frame_seen_reg, frame_seen_next;
    logic             off_reg, off_next;
    logic             text_reg, text_next;
    logic [1:0]       focus_reg, focus_next;
    logic [2:0]       kind_reg, kind_next;
    logic             rsp_valid_reg, rsp_valid_next;
    out_word_t        rsp_reg, rsp_next;

    logic             accept;
    logic             shift_en;
    logic             probe_in_ctl;
    region_t          region_new;
    probe_t           probe_in;
    probe_t           probe_out;
    logic [1:0]       fallback;
    logic [1:0]       hit_layer;
    logic             region_ok;
    logic             needs_scan;

    ifrr_chain #(
        .MAX_REGIONS (MAX_REGIONS),
        .CNT_W       (CNT_W)
    ) u_chain (
        .clk        (clk),
        .rst_n      (rst_n),
        .shift_en   (shift_en),
        .region_new (region_new),
        .probe_in   (probe_in),
        .count_in   (count_reg),
        .probe_out  (probe_out)
    );

    // only one word in flight; a held response frees in the accepting cycle
    assign req_ready = (state_reg == ST_IDLE) && (!rsp_valid_reg || rsp_ready);
    assign accept    = req_valid && req_ready;

    // layer code three saturates to gameplay as a fallback
    assign fallback  = (req.layer_code > LAYER_GAME) ? LAYER_GAME : req.layer_code;

    assign region_ok = ((req.layer_code == LAYER_UI) || (req.layer_code == LAYER_GAME)) &&
                       (req.edge_right > req.edge_left) && (req.edge_bottom > req.edge_top);

    assign needs_scan = ((req.event_kind == KIND_BUTTON) && req.button_down) ||
                        (req.event_kind == KIND_MOVE) || (req.event_kind == KIND_WHEEL);

    assign hit_layer = probe_out.hit ? probe_out.layer : LAYER_UI;

    always_comb
    begin
        region_new.left   = req.edge_left;
        region_new.top    = req.edge_top;
        region_new.right  = req.edge_right;
        region_new.bottom = req.edge_bottom;
        region_new.layer  = req.layer_code;
        probe_in.valid    = probe_in_ctl;
        probe_in.x        = pos_to_fix(req.pointer_x);
        probe_in.y        = pos_to_fix(req.pointer_y);
        probe_in.hit      = 1'b0;
        probe_in.layer    = LAYER_UI;
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        frame_seen_next = frame_seen_reg;
        off_next        = off_reg;
        text_next       = text_reg;
        focus_next      = focus_reg;
        kind_next       = kind_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_next        = rsp_reg;
        shift_en        = 1'b0;
        probe_in_ctl    = 1'b0;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = '0;
                    case (req.func)
                        FUNC_BEGIN:
                        begin
                            count_next      = '0;
                            frame_seen_next = 1'b1;
                            off_next        = req.disable_flag;
                            text_next       = req.text_entry_flag;
                            if (req.disable_flag)
                            begin
                                focus_next = LAYER_UI;
                            end
                        end
                        FUNC_REGISTER:
                        begin
                            if (region_ok && (count_reg != CNT_W'(MAX_REGIONS)))
                            begin
                                shift_en   = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                            else
                            begin
                                rsp_next.region_dropped = 1'b1;
                            end
                        end
                        FUNC_RESOLVE:
                        begin
                            if (!frame_seen_reg)
                            begin
                                rsp_next.routed_layer = fallback;
                            end
                            else if (off_reg)
                            begin
                                rsp_next.routed_layer = LAYER_UI;
                            end
                            else if (needs_scan)
                            begin
                                // answer comes back from the end of the cell row
                                rsp_valid_next = 1'b0;
                                probe_in_ctl   = 1'b1;
                                kind_next      = req.event_kind;
                                state_next     = ST_SCAN;
                            end
                            else if (req.event_kind == KIND_KEYBOARD)
                            begin
                                rsp_next.routed_layer =
                                    (text_reg && (focus_reg != LAYER_GAME)) ? LAYER_UI : focus_reg;
                            end
                            else
                            begin
                                rsp_next.routed_layer =
                                    (focus_reg != LAYER_SYSTEM) ? focus_reg : fallback;
                            end
                        end
                        default:
                        begin
                            rsp_next = '0;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (probe_out.valid)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = '0;
                    state_next     = ST_IDLE;
                    case (kind_reg)
                        KIND_BUTTON:
                        begin
                            // press takes focus; gameplay focus ends text entry
                            focus_next            = hit_layer;
                            rsp_next.routed_layer = hit_layer;
                            if (hit_layer == LAYER_GAME)
                            begin
                                text_next = 1'b0;
                            end
                        end
                        KIND_MOVE:
                        begin
                            rsp_next.routed_layer =
                                ((focus_reg == LAYER_GAME) && (hit_layer == LAYER_GAME)) ?
                                LAYER_GAME : LAYER_UI;
                        end
                        default:
                        begin
                            rsp_next.routed_layer = hit_layer;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            frame_seen_reg <= 1'b0;
            off_reg        <= 1'b0;
            text_reg       <= 1'b0;
            focus_reg      <= LAYER_SYSTEM;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            frame_seen_reg <= frame_seen_next;
            off_reg        <= off_next;
            text_reg       <= text_next;
            focus_reg      <= focus_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        rsp_reg  <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_REGIONS))
        else $error("region count above table size");

    a_probe_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        probe_out.valid |-> (state_reg == ST_SCAN))
        else $error("probe left the cell row outside a scan");

    a_scan_no_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> !rsp_valid_reg)
        else $error("response pending during a scan");

    a_register_answers: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req.func == FUNC_REGISTER)) |=> rsp_valid_reg)
        else $error("register word gave no response");
`endif

endmodule

`default_nettype wire
